// File: rtl/lcc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and functions of the Luhn card number classifier.
// No dependencies; every module of the block imports this package.
package lcc_pkg;

    localparam int NUM_W      = 63;
    localparam int BIN_W      = 64;
    localparam int DIGITS     = 19;
    localparam int BCD_W      = 4 * DIGITS;
    localparam int CHUNK      = 8;
    localparam int STAGES     = BIN_W / CHUNK;
    localparam int CNT_W      = 5;
    localparam int PSUM_W     = 6;
    localparam int SUM_W      = 8;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 8;

    localparam logic [1:0] CLASS_INVALID = 2'd0;
    localparam logic [1:0] CLASS_34_37   = 2'd1;
    localparam logic [1:0] CLASS_51_55   = 2'd2;
    localparam logic [1:0] CLASS_4X      = 2'd3;

    typedef logic [BCD_W-1:0] bcd_t;

    typedef struct packed {
        logic [PSUM_W-1:0] sum_a;
        logic [PSUM_W-1:0] sum_b;
        logic [PSUM_W-1:0] sum_c;
        logic [CNT_W-1:0]  digit_count;
        logic [3:0]        lead_hi;
        logic [3:0]        lead_lo;
    } luhn_t;

    // One double-dabble step: adjust each digit, then shift in the next bit.
    function automatic bcd_t dabble_bit(input bcd_t bcd, input logic b);
        bcd_t adj;
        logic [3:0] d;
        adj = bcd;
        for (int i = 0; i < DIGITS; i++) begin
            d = bcd[4*i +: 4];
            if (d >= 4'd5) begin
                adj[4*i +: 4] = d + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], b};
    endfunction

    // Luhn weight of one digit; odd positions are doubled and digit-summed.
    function automatic logic [3:0] luhn_weight(input logic [3:0] d, input logic odd);
        logic [4:0] t;
        t = {d, 1'b0};
        if (!odd) begin
            return d;
        end else if (t > 5'd9) begin
            return 4'(t - 5'd9);
        end else begin
            return t[3:0];
        end
    endfunction

endpackage

// File: rtl/lcc_dabble_stage.sv
`timescale 1ns / 1ps
// One pipeline stage of the binary to decimal conversion: eight dabble steps.
// Depends on lcc_pkg.
module lcc_dabble_stage (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      advance,
    input  logic                      in_valid,
    input  lcc_pkg::bcd_t             in_bcd,
    input  logic [lcc_pkg::BIN_W-1:0] in_bin,
    output logic                      out_valid,
    output lcc_pkg::bcd_t             out_bcd,
    output logic [lcc_pkg::BIN_W-1:0] out_bin
);
    import lcc_pkg::*;

    logic              valid_reg;
    bcd_t              bcd_reg;
    bcd_t              bcd_next;
    logic [BIN_W-1:0]  bin_reg;
    logic [BIN_W-1:0]  bin_next;

    always_comb begin
        bcd_next = in_bcd;
        for (int i = 0; i < CHUNK; i++) begin
            bcd_next = dabble_bit(bcd_next, in_bin[BIN_W-1-i]);
        end
        bin_next = {in_bin[BIN_W-CHUNK-1:0], {CHUNK{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            bcd_reg <= bcd_next;
            bin_reg <= bin_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_bcd   = bcd_reg;
    assign out_bin   = bin_reg;

endmodule

// File: rtl/lcc_luhn_stage.sv
`timescale 1ns / 1ps
// Luhn stage: digit weights, partial sums, digit count and leading digits.
// Depends on lcc_pkg.
module lcc_luhn_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           advance,
    input  logic           in_valid,
    input  lcc_pkg::bcd_t  in_bcd,
    output logic           out_valid,
    output lcc_pkg::luhn_t out_luhn
);
    import lcc_pkg::*;

    logic        valid_reg;
    luhn_t       luhn_reg;
    luhn_t       luhn_next;
    logic [3:0]  w [DIGITS];
    logic [CNT_W-1:0] cnt;

    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            w[i] = luhn_weight(in_bcd[4*i +: 4], i[0]);
        end
        luhn_next.sum_a = '0;
        luhn_next.sum_b = '0;
        luhn_next.sum_c = '0;
        for (int i = 0; i < 7; i++) begin
            luhn_next.sum_a = luhn_next.sum_a + PSUM_W'(w[i]);
        end
        for (int i = 7; i < 13; i++) begin
            luhn_next.sum_b = luhn_next.sum_b + PSUM_W'(w[i]);
        end
        for (int i = 13; i < DIGITS; i++) begin
            luhn_next.sum_c = luhn_next.sum_c + PSUM_W'(w[i]);
        end
        cnt = '0;
        for (int i = 0; i < DIGITS; i++) begin
            if (in_bcd[4*i +: 4] != 4'd0) begin
                cnt = CNT_W'(i + 1);
            end
        end
        luhn_next.digit_count = cnt;
        case (cnt)
            5'd16: begin
                luhn_next.lead_hi = in_bcd[4*15 +: 4];
                luhn_next.lead_lo = in_bcd[4*14 +: 4];
            end
            5'd15: begin
                luhn_next.lead_hi = in_bcd[4*14 +: 4];
                luhn_next.lead_lo = in_bcd[4*13 +: 4];
            end
            5'd13: begin
                luhn_next.lead_hi = in_bcd[4*12 +: 4];
                luhn_next.lead_lo = in_bcd[4*11 +: 4];
            end
            default: begin
                luhn_next.lead_hi = 4'd0;
                luhn_next.lead_lo = 4'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            luhn_reg <= luhn_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_luhn  = luhn_reg;

endmodule

// File: rtl/lcc_classify_stage.sv
`timescale 1ns / 1ps
// Final stage: Luhn total modulo ten, issuer pattern match, output register.
// Depends on lcc_pkg.
module lcc_classify_stage (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      advance,
    input  logic                      in_valid,
    input  lcc_pkg::luhn_t            in_luhn,
    output logic                      out_valid,
    output logic [1:0]                card_class,
    output logic [lcc_pkg::CNT_W-1:0] digit_count,
    output logic                      checksum_ok
);
    import lcc_pkg::*;

    logic             valid_reg;
    logic [1:0]       class_reg;
    logic [1:0]       class_next;
    logic [CNT_W-1:0] count_reg;
    logic             ok_reg;
    logic             ok_next;
    logic [SUM_W-1:0] total;
    logic [15:0]      prod;
    logic [SUM_W-1:0] quot;
    logic [SUM_W-1:0] rem;

    always_comb begin
        total = SUM_W'(in_luhn.sum_a) + SUM_W'(in_luhn.sum_b) + SUM_W'(in_luhn.sum_c);
        prod  = 16'(total) * 16'd205;
        quot  = SUM_W'(prod >> 11);
        rem   = total - SUM_W'(16'(quot) * 16'd10);
        ok_next = (rem == '0);
        class_next = CLASS_INVALID;
        if (ok_next) begin
            if (in_luhn.digit_count == 5'd16 && in_luhn.lead_hi == 4'd5
                && in_luhn.lead_lo >= 4'd1 && in_luhn.lead_lo <= 4'd5) begin
                class_next = CLASS_51_55;
            end else if (in_luhn.digit_count == 5'd15 && in_luhn.lead_hi == 4'd3
                && (in_luhn.lead_lo == 4'd4 || in_luhn.lead_lo == 4'd7)) begin
                class_next = CLASS_34_37;
            end else if ((in_luhn.digit_count == 5'd13 || in_luhn.digit_count == 5'd16)
                && in_luhn.lead_hi == 4'd4) begin
                class_next = CLASS_4X;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            class_reg <= class_next;
            count_reg <= in_luhn.digit_count;
            ok_reg    <= ok_next;
        end
    end

    assign out_valid   = valid_reg;
    assign card_class  = class_reg;
    assign digit_count = count_reg;
    assign checksum_ok = ok_reg;

endmodule

// File: rtl/luhn_card_number_classifier.sv
`timescale 1ns / 1ps
// Luhn card number classifier, top level: one word in, one word out, ten
// register stages deep. Eight stages convert the 63-bit binary number to 19
// decimal digits, eight bits per stage; one stage forms the Luhn partial sums,
// the digit count and the leading digits; the last stage takes the total
// modulo ten, matches the issuer patterns and holds the result word. A new
// word is accepted every cycle while the result side takes words. All stages
// advance together, so a stall at the output holds the whole pipeline.
// Depends on lcc_pkg, lcc_dabble_stage, lcc_luhn_stage and lcc_classify_stage.
module luhn_card_number_classifier (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lcc_pkg::IN_DATA_W-1:0]   s_tdata,   // [62:0] card_number
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lcc_pkg::OUT_DATA_W-1:0]  m_tdata    // [1:0] card_class,
                                                       // [6:2] digit_count,
                                                       // [7] checksum_ok
);
    import lcc_pkg::*;

    logic             advance;
    logic             valid_q [STAGES+1];
    bcd_t             bcd_q   [STAGES+1];
    logic [BIN_W-1:0] bin_q   [STAGES+1];
    logic             luhn_valid;
    luhn_t            luhn;
    logic [1:0]       card_class;
    logic [CNT_W-1:0] digit_count;
    logic             checksum_ok;

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    assign valid_q[0] = s_tvalid;
    assign bcd_q[0]   = '0;
    assign bin_q[0]   = {1'b0, s_tdata[NUM_W-1:0]};

    for (genvar g = 0; g < STAGES; g++) begin : g_dabble
        lcc_dabble_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .in_valid  (valid_q[g]),
            .in_bcd    (bcd_q[g]),
            .in_bin    (bin_q[g]),
            .out_valid (valid_q[g+1]),
            .out_bcd   (bcd_q[g+1]),
            .out_bin   (bin_q[g+1])
        );
    end

    lcc_luhn_stage u_luhn (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (valid_q[STAGES]),
        .in_bcd    (bcd_q[STAGES]),
        .out_valid (luhn_valid),
        .out_luhn  (luhn)
    );

    lcc_classify_stage u_classify (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .in_valid    (luhn_valid),
        .in_luhn     (luhn),
        .out_valid   (m_tvalid),
        .card_class  (card_class),
        .digit_count (digit_count),
        .checksum_ok (checksum_ok)
    );

    assign m_tdata = {checksum_ok, digit_count, card_class};

`ifndef SYNTHESIS
    a_class_needs_checksum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && card_class != CLASS_INVALID |-> checksum_ok)
        else $error("card class set without a passing checksum");

    a_class_needs_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && card_class != CLASS_INVALID |->
            (digit_count == 5'd13 || digit_count == 5'd15 || digit_count == 5'd16))
        else $error("card class set with a bad digit count");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> digit_count <= 5'(DIGITS))
        else $error("digit count beyond nineteen");

    a_class_3437_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && card_class == CLASS_34_37 |-> digit_count == 5'd15)
        else $error("34/37 class without fifteen digits");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> luhn_valid == $past(luhn_valid) && $stable(luhn))
        else $error("pipeline moved during a stall");
`endif

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Testbench for luhn_card_number_classifier: streams card numbers with random gaps and stalls,
// predicts class, digit count and Luhn flag per word and checks every result word in order.
// Depends on lcc_pkg and the luhn_card_number_classifier RTL.
module testbench;
    import lcc_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int RANDOM_WORDS = 1400;
    localparam int LONG_HOLD    = 300;

    typedef struct packed {
        logic       checksum_ok;
        logic [4:0] digit_count;
        logic [1:0] card_class;
    } card_verdict_t;

    class card_scoreboard;
        card_verdict_t verdict_q[$];
        int mismatches;

        function card_verdict_t classify_card(logic [62:0] num);
            card_verdict_t v;
            longint unsigned rest;
            longint unsigned lead;
            int unsigned sum;
            int unsigned d;
            int len;
            int hi;
            int lo;
            rest = {1'b0, num};
            sum = 0;
            len = 0;
            while (rest != 0) begin
                d = rest % 10;
                rest = rest / 10;
                if (len % 2 == 1) begin
                    d = 2 * d;
                    if (d > 9) begin
                        d = d - 9;
                    end
                end
                sum += d;
                len++;
            end
            v.digit_count = 5'(len);
            v.checksum_ok = (sum % 10 == 0);
            v.card_class = CLASS_INVALID;
            if (v.checksum_ok && (len == 13 || len == 15 || len == 16)) begin
                lead = {1'b0, num};
                for (int j = 2; j < len; j++) begin
                    lead = lead / 10;
                end
                hi = int'(lead / 10);
                lo = int'(lead % 10);
                if (len == 16 && hi == 5 && lo >= 1 && lo <= 5) begin
                    v.card_class = CLASS_51_55;
                end else if (len == 15 && hi == 3 && (lo == 4 || lo == 7)) begin
                    v.card_class = CLASS_34_37;
                end else if ((len == 13 || len == 16) && hi == 4) begin
                    v.card_class = CLASS_4X;
                end
            end
            return v;
        endfunction

        function void note_input(logic [62:0] num);
            verdict_q.push_back(classify_card(num));
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] word);
            card_verdict_t got;
            card_verdict_t exp_v;
            got = word;
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result word %h", word);
                end
                return;
            end
            exp_v = verdict_q.pop_front();
            if (got != exp_v) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display({"mismatch: class exp %0d got %0d, count exp %0d got %0d,",
                              " ok exp %0d got %0d"},
                             exp_v.card_class, got.card_class, exp_v.digit_count,
                             got.digit_count, exp_v.checksum_ok, got.checksum_ok);
                end
            end
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    card_scoreboard sb = new();
    int idle_cycles = 0;

    luhn_card_number_classifier dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int draw_gap(bit steady);
        return steady ? 0 : $urandom_range(0, 10);
    endfunction

    function automatic int luhn_check_digit(longint unsigned body);
        int unsigned sum;
        int unsigned d;
        int k;
        sum = 0;
        k = 1;
        while (body != 0) begin
            d = body % 10;
            body = body / 10;
            if (k % 2 == 1) begin
                d = 2 * d;
                if (d > 9) begin
                    d = d - 9;
                end
            end
            sum += d;
            k++;
        end
        return (10 - sum % 10) % 10;
    endfunction

    // prefix of pdig digits, random middle, valid check digit; len at most 18
    function automatic logic [62:0] make_card(longint unsigned prefix, int pdig, int len);
        longint unsigned body;
        body = prefix;
        for (int i = pdig; i < len - 1; i++) begin
            body = body * 10 + $urandom_range(0, 9);
        end
        return 63'(body * 10 + luhn_check_digit(body));
    endfunction

    function automatic logic [62:0] break_check(logic [62:0] num);
        longint unsigned v;
        longint unsigned d;
        v = {1'b0, num};
        d = v % 10;
        return 63'(v - d + (d + 1 + $urandom_range(0, 8)) % 10);
    endfunction

    function automatic logic [62:0] wellformed_card();
        case ($urandom_range(0, 2))
            0: return make_card(($urandom_range(0, 1) == 0) ? 34 : 37, 2, 15);
            1: return make_card(51 + $urandom_range(0, 4), 2, 16);
            default: return make_card(40 + $urandom_range(0, 9), 2,
                                      ($urandom_range(0, 1) == 0) ? 13 : 16);
        endcase
    endfunction

    function automatic logic [62:0] random_card();
        int r;
        int len;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            return wellformed_card();
        end else if (r < 60) begin
            len = 12 + $urandom_range(0, 5);
            return make_card($urandom_range(10, 99), 2, len);
        end else if (r < 70) begin
            return break_check(wellformed_card());
        end else if (r < 85) begin
            len = $urandom_range(1, 18);
            return make_card($urandom_range(1, 9), 1, len);
        end else begin
            return 63'({$urandom, $urandom} >> $urandom_range(0, 62));
        end
    endfunction

    task automatic send_word(logic [62:0] num, bit steady);
        int gap;
        gap = draw_gap(steady);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, num};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_directed();
        send_word(63'd0, 0);
        send_word(63'h7FFF_FFFF_FFFF_FFFF, 0);
        send_word(63'd1, 0);
        send_word(63'd9, 0);
        send_word(63'd1000000000000000000, 0);
        send_word(63'h5555_5555_5555_5555, 0);
        send_word(63'h2AAA_AAAA_AAAA_AAAA, 0);
        send_word(make_card(34, 2, 15), 0);
        send_word(make_card(37, 2, 15), 0);
        send_word(make_card(51, 2, 16), 0);
        send_word(make_card(55, 2, 16), 0);
        send_word(make_card(4, 1, 13), 0);
        send_word(make_card(4, 1, 16), 0);
        send_word(make_card(50, 2, 16), 0);
        send_word(make_card(56, 2, 16), 0);
        send_word(make_card(35, 2, 15), 0);
        send_word(make_card(4, 1, 15), 0);
        send_word(make_card(34, 2, 16), 0);
        send_word(make_card(4, 1, 14), 0);
        send_word(make_card(53, 2, 15), 0);
        send_word(break_check(make_card(4, 1, 16)), 0);
        send_word(break_check(make_card(37, 2, 15)), 0);
        send_word(make_card(1, 1, 12), 0);
        send_word(make_card(9, 1, 18), 0);
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        m_tready <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        send_directed();
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i == 1100) begin
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (sb.pending() != 0);
            end
            send_word(random_card(), i >= 700 && i < 900);
        end
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (20) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        int taken;
        int gap;
        bit held;
        taken = 0;
        held = 0;
        wait (aresetn);
        forever begin
            if (!held && taken >= 400) begin
                held = 1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            gap = draw_gap(taken >= 700 && taken < 900);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_input(s_tdata[62:0]);
            end
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
